### rtl/core/sha256_pkg.sv
// ---------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and a rotate helper for the stream hasher.
// ---------------------------------------------------------------------------
package sha256_pkg;

    localparam int WordBits   = 32;
    localparam int DigestWords = 8;
    localparam int BlockBytes = 64;
    localparam int LengthOffset = 56;
    localparam logic [7:0] PadMark = 8'h80;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_FILL,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    // where the controller goes once a block is folded into the chain
    typedef enum logic [1:0] {
        POST_IDLE,
        POST_PAD,
        POST_FILL,
        POST_EMIT
    } post_t;

    // controller -> datapath commands
    typedef struct packed {
        logic       wr_byte;    // shift wr_data into the block, count++
        logic       wr_pad;     // shift wr_data into the block
        logic [7:0] wr_data;
        logic       comp_start; // load working vars from chain
        logic       comp_round; // run one round
        logic       comp_fold;  // add working vars into chain
        logic       emit_next;  // step to the next digest word
        logic       restart;    // chain, count and digest word index to initial values
    } cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic [63:0] byte_count;
        logic [5:0]  round;
    } stat_t;

    localparam logic [31:0] InitHash [DigestWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

### rtl/core/sha256_ctrl.sv
// ---------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte absorb, padding, rounds and digest output.
// ---------------------------------------------------------------------------
module sha256_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_beat,
    input  logic [7:0]         in_byte,
    input  logic               in_present,
    input  logic               in_last,
    input  logic               out_beat,
    input  logic               out_final,
    input  sha256_pkg::stat_t  stat,
    output sha256_pkg::cmd_t   cmd,
    output logic               in_ready,
    output logic               out_busy
);

    sha256_pkg::state_t state_reg, state_next;
    sha256_pkg::post_t  post_reg, post_next;   // target after the chain update
    logic        lenblk_reg, lenblk_next;      // this fill block ends with the length
    logic [5:0]  pos_reg, pos_next;            // fill write offset
    logic [5:0]  off;
    logic [63:0] len_bits;

    assign off      = stat.byte_count[5:0];
    assign len_bits = {stat.byte_count[60:0], 3'b000};

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sha256_pkg::ST_IDLE;
            post_reg   <= sha256_pkg::POST_IDLE;
            lenblk_reg <= 1'b0;
            pos_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            post_reg   <= post_next;
            lenblk_reg <= lenblk_next;
            pos_reg    <= pos_next;
        end
    end

    // next state
    always_comb
    begin
        state_next  = state_reg;
        post_next   = post_reg;
        lenblk_next = lenblk_reg;
        pos_next    = pos_reg;
        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    // a byte at offset 63 completes the block
                    if (in_present && off == 6'd63)
                    begin
                        state_next = sha256_pkg::ST_LOAD;
                        post_next  = in_last ? sha256_pkg::POST_PAD : sha256_pkg::POST_IDLE;
                    end
                    else if (in_last)
                        state_next = sha256_pkg::ST_PAD;
                end
            end
            sha256_pkg::ST_PAD:
            begin
                // 0x80 at the current offset; length fits only below offset 56
                pos_next    = off + 6'd1;
                lenblk_next = (off < 6'(sha256_pkg::LengthOffset)) || (off == 6'd63);
                if (off == 6'd63)
                begin
                    state_next = sha256_pkg::ST_LOAD;
                    post_next  = sha256_pkg::POST_FILL;
                end
                else
                    state_next = sha256_pkg::ST_FILL;
            end
            sha256_pkg::ST_FILL:
            begin
                // one byte a cycle up to the end of the block
                pos_next = pos_reg + 6'd1;
                if (pos_reg == 6'd63)
                begin
                    state_next  = sha256_pkg::ST_LOAD;
                    post_next   = lenblk_reg ? sha256_pkg::POST_EMIT : sha256_pkg::POST_FILL;
                    lenblk_next = 1'b1;
                end
            end
            sha256_pkg::ST_LOAD:
                state_next = sha256_pkg::ST_ROUND;
            sha256_pkg::ST_ROUND:
            begin
                if (stat.round == 6'd63)
                    state_next = sha256_pkg::ST_FOLD;
            end
            sha256_pkg::ST_FOLD:
            begin
                case (post_reg)
                    sha256_pkg::POST_PAD:  state_next = sha256_pkg::ST_PAD;
                    sha256_pkg::POST_FILL: state_next = sha256_pkg::ST_FILL;
                    sha256_pkg::POST_EMIT: state_next = sha256_pkg::ST_EMIT;
                    default:               state_next = sha256_pkg::ST_IDLE;
                endcase
            end
            sha256_pkg::ST_EMIT:
            begin
                if (out_beat && out_final)
                    state_next = sha256_pkg::ST_IDLE;
            end
            default: state_next = sha256_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = (state_reg == sha256_pkg::ST_IDLE);
        out_busy = (state_reg == sha256_pkg::ST_EMIT);
        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                cmd.wr_byte = in_beat && in_present;
                cmd.wr_data = in_byte;
            end
            sha256_pkg::ST_PAD:
            begin
                cmd.wr_pad  = 1'b1;
                cmd.wr_data = sha256_pkg::PadMark;
            end
            sha256_pkg::ST_FILL:
            begin
                // zeros, then in a length block the big-endian bit length in the last eight bytes
                cmd.wr_pad = 1'b1;
                if (lenblk_reg && pos_reg >= 6'(sha256_pkg::LengthOffset))
                    cmd.wr_data = len_bits[{~pos_reg[2:0], 3'b000} +: 8];
            end
            sha256_pkg::ST_LOAD:
                cmd.comp_start = 1'b1;
            sha256_pkg::ST_ROUND:
                cmd.comp_round = 1'b1;
            sha256_pkg::ST_FOLD:
                cmd.comp_fold = 1'b1;
            sha256_pkg::ST_EMIT:
            begin
                cmd.emit_next = out_beat;
                cmd.restart   = out_beat && out_final;
            end
            default: ;
        endcase
    end

endmodule

### rtl/core/sha256_dp.sv
// ---------------------------------------------------------------------------
// SHA-256 datapath
// Block shift register and schedule window, round unit, chain words and
// digest word select.
// ---------------------------------------------------------------------------
module sha256_dp
(
    input  logic               clk,
    input  logic               rst_n,
    input  sha256_pkg::cmd_t   cmd,
    output sha256_pkg::stat_t  stat,
    output logic [31:0]        out_word,
    output logic               out_final
);

    // block bytes shift in at the bottom; during rounds it is the schedule
    // window with the oldest word at the top
    logic [511:0] blk_reg;
    logic [31:0]  v_reg [8];
    logic [31:0]  h_reg [8];
    logic [63:0]  cnt_reg;
    logic [5:0]   rnd_reg;
    logic [2:0]   word_reg;

    logic [31:0] w_old, w_p1, w_p9, w_p14;
    logic [31:0] w_cur, s0, s1, t1, t2, big0, big1, ch, maj;

    assign w_old = blk_reg[511:480];
    assign w_p1  = blk_reg[479:448];
    assign w_p9  = blk_reg[223:192];
    assign w_p14 = blk_reg[63:32];

    // block bytes, then schedule window
    always_ff @(posedge clk)
    begin
        if (cmd.wr_byte || cmd.wr_pad)
            blk_reg <= {blk_reg[503:0], cmd.wr_data};
        else if (cmd.comp_round)
            blk_reg <= {blk_reg[479:0], w_cur};
    end

    // byte count and chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= sha256_pkg::InitHash[i];
        end
        else
        begin
            if (cmd.restart)
                cnt_reg <= '0;
            else if (cmd.wr_byte)
                cnt_reg <= cnt_reg + 64'd1;
            if (cmd.restart)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= sha256_pkg::InitHash[i];
            end
            else if (cmd.comp_fold)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    // schedule word: block words for rounds 0..15, recurrence after
    always_comb
    begin
        s0 = sha256_pkg::rotr(w_p1, 7) ^ sha256_pkg::rotr(w_p1, 18) ^ (w_p1 >> 3);
        s1 = sha256_pkg::rotr(w_p14, 17) ^ sha256_pkg::rotr(w_p14, 19) ^ (w_p14 >> 10);
        if (rnd_reg < 6'd16)
            w_cur = w_old;
        else
            w_cur = s1 + w_p9 + s0 + w_old;
    end

    // round function on the working set
    always_comb
    begin
        big1 = sha256_pkg::rotr(v_reg[4], 6) ^ sha256_pkg::rotr(v_reg[4], 11) ^
               sha256_pkg::rotr(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + big1 + ch + sha256_pkg::RoundConst[rnd_reg] + w_cur;
        big0 = sha256_pkg::rotr(v_reg[0], 2) ^ sha256_pkg::rotr(v_reg[0], 13) ^
               sha256_pkg::rotr(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = big0 + maj;
    end

    // round counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rnd_reg <= '0;
        else if (cmd.comp_start)
            rnd_reg <= '0;
        else if (cmd.comp_round)
            rnd_reg <= rnd_reg + 6'd1;
    end

    // working variables
    always_ff @(posedge clk)
    begin
        if (cmd.comp_start)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
        else if (cmd.comp_round)
        begin
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
        end
    end

    // digest word index, word 0 first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            word_reg <= '0;
        else if (cmd.restart)
            word_reg <= '0;
        else if (cmd.emit_next)
            word_reg <= word_reg + 3'd1;
    end

    assign out_word  = h_reg[word_reg];
    assign out_final = (word_reg == 3'd7);
    assign stat.byte_count = cnt_reg;
    assign stat.round      = rnd_reg;

endmodule

### rtl/core/sha256_stream_hasher.sv
// The first digest word follows the final beat once the pad fill (one byte a
// cycle) and one or two block compressions are done. Throughput: one data beat
// a cycle while idle; a beat that fills a block holds tready low through load,
// 64 rounds and chain update; digest beats one a cycle while m_tready is high.
// Reset (rst_n low, async) loads the initial hash and clears the count.
// ---------------------------------------------------------------------------
// SHA-256 stream hasher, top level
// Byte stream in, eight digest words out.
// ---------------------------------------------------------------------------
module sha256_stream_hasher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // byte_present
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic        m_tlast    // digest_last
);

    sha256_pkg::cmd_t  cmd;
    sha256_pkg::stat_t stat;
    logic out_busy, out_final, in_ready;

    sha256_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_beat    (s_tvalid && in_ready),
        .in_byte    (s_tdata),
        .in_present (s_tuser),
        .in_last    (s_tlast),
        .out_beat   (out_busy && m_tready),
        .out_final  (out_final),
        .stat       (stat),
        .cmd        (cmd),
        .in_ready   (in_ready),
        .out_busy   (out_busy)
    );

    sha256_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .out_word  (m_tdata),
        .out_final (out_final)
    );

    assign s_tready = in_ready;
    assign m_tvalid = out_busy;
    assign m_tlast  = out_final;

endmodule

### sim/sha256_stream_hasher_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Streams messages byte by byte with random gaps and backpressure, predicts
// each digest with a behavioral SHA-256 and checks all eight output words.
// ---------------------------------------------------------------------------
module sha256_stream_hasher_tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } digest_beat_t;

    // predictor state
    logic [31:0] hash_state [sha256_pkg::DigestWords];
    logic [7:0]  msg_block [sha256_pkg::BlockBytes];
    logic [63:0] msg_bytes;

    digest_beat_t digest_q [$];
    int errors = 0;
    int beats_sent = 0;
    int digests_seen = 0;
    bit rx_stall_off = 1'b0;

    sha256_stream_hasher u_dut (.*);

    always #4 clk = ~clk;

    // mostly short gaps, occasionally long
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        else if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_msg_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int r = 0; r < 16; r++)
            w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
        for (int r = 16; r < 64; r++)
            w[r] = (ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
                 + (ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
        for (int i = 0; i < 8; i++)
            v[i] = hash_state[i];
        for (int r = 0; r < 64; r++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundConst[r] + w[r];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--)
                v[i] = v[i-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += v[i];
    endtask

    task automatic hash_restart();
        for (int i = 0; i < sha256_pkg::DigestWords; i++)
            hash_state[i] = sha256_pkg::InitHash[i];
        msg_bytes = '0;
    endtask

    // absorb one accepted beat, queue the digest on end of message
    task automatic absorb_beat(logic [7:0] b, logic present, logic eom);
        logic [63:0] bits;
        int pos;
        digest_beat_t d;
        if (present)
        begin
            msg_block[msg_bytes[5:0]] = b;
            msg_bytes++;
            if (msg_bytes[5:0] == 6'd0)
                compress_msg_block();
        end
        if (!eom)
            return;
        bits = msg_bytes << 3;
        pos = int'(msg_bytes[5:0]);
        msg_block[pos] = sha256_pkg::PadMark;
        pos++;
        if (pos > sha256_pkg::LengthOffset)
        begin
            while (pos < sha256_pkg::BlockBytes)
            begin
                msg_block[pos] = 8'h00;
                pos++;
            end
            compress_msg_block();
            pos = 0;
        end
        while (pos < sha256_pkg::LengthOffset)
        begin
            msg_block[pos] = 8'h00;
            pos++;
        end
        for (int k = 0; k < 8; k++)
            msg_block[sha256_pkg::LengthOffset + k] = bits[63 - 8*k -: 8];
        compress_msg_block();
        for (int k = 0; k < sha256_pkg::DigestWords; k++)
        begin
            d.word = hash_state[k];
            d.last = (k == sha256_pkg::DigestWords - 1);
            digest_q.push_back(d);
        end
        hash_restart();
    endtask

    // drive one beat, wait for acceptance
    task automatic send_beat(logic [7:0] b, logic present, logic eom, bit idle_ok = 1);
        int g;
        g = idle_ok ? gap_len() : 0;
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= present;
        s_tlast  <= eom;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        absorb_beat(b, present, eom);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_message(int len, bit empty_final, bit idle_ok = 1);
        for (int i = 0; i < len; i++)
        begin
            if (!empty_final && i == len - 1)
                send_beat(8'($urandom), 1'b1, 1'b1, idle_ok);
            else
                send_beat(8'($urandom), 1'b1, 1'b0, idle_ok);
        end
        if (empty_final || len == 0)
            send_beat(8'($urandom), 1'b0, 1'b1, idle_ok);
    endtask

    // output side: random backpressure, check each beat
    initial
    begin
        digest_beat_t exp;
        int g;
        forever
        begin
            @(negedge clk);
            g = rx_stall_off ? 0 : gap_len();
            if (g > 0)
            begin
                m_tready <= 1'b0;
                repeat (g) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (digest_q.size() == 0)
                begin
                    $error("digest beat with nothing expected: %h", m_tdata);
                    errors++;
                end
                else
                begin
                    exp = digest_q.pop_front();
                    if (m_tdata !== exp.word)
                    begin
                        $error("digest_word expected %h actual %h", exp.word, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== exp.last)
                    begin
                        $error("digest_last expected %b actual %b", exp.last, m_tlast);
                        errors++;
                    end
                    if (exp.last)
                        digests_seen++;
                end
            end
        end
    end

    // empty message, ignored empty beats, extreme byte values
    task automatic test_directed();
        send_beat(8'hff, 1'b0, 1'b1);
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hff, 1'b1, 1'b0);
        send_beat(8'haa, 1'b0, 1'b0);
        send_beat(8'h55, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
    endtask

    // pad at offset 56 (extra length block), final byte that fills a block
    task automatic test_boundaries();
        send_message(56, 1'b1, 1'b1);
        send_message(64, 1'b0, 1'b0);
    endtask

    // short random messages with random empty beats mixed in
    task automatic test_random();
        int len;
        rx_stall_off = 1'b0;
        while (beats_sent < 150)
        begin
            len = $urandom_range(0, 20);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_beat(8'($urandom), 1'b0, 1'b0);
                send_beat(8'($urandom), 1'b1, 1'b0);
            end
            send_beat(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
        end
        // a burst with no idling on either side
        rx_stall_off = 1'b1;
        send_message(5, 1'b0, 1'b0);
        send_message(3, 1'b1, 1'b0);
        rx_stall_off = 1'b0;
    endtask

    initial
    begin
        hash_restart();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_boundaries();
        test_random();
        s_tvalid <= 1'b0;
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Sent %0d input beats and checked %0d digests", beats_sent, digests_seen);
        $display("Covered empty, padded-boundary, multi-block and random messages.");
        if (errors == 0)
            $display("sha256_stream_hasher_tb passed");
        else
            $display("sha256_stream_hasher_tb failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("sha256_stream_hasher_tb failed");
        $finish;
    end

endmodule
